[design/gpioirq_pkg.sv]
// gpioirq_pkg: codes and field widths shared by the gpio edge-interrupt block
// and its port checker
// no dependencies
package gpioirq_pkg;

    // default pin count
    localparam int PIN_COUNT_DEF = 16;

    // pins covered by the configuration registers and by all_levels
    localparam int CFG_PINS = 16;

    // field widths
    localparam int REQ_W    = 2;
    localparam int PIDX_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LEVELS_W = 16;
    localparam int IRQPIN_W = 4;
    localparam int CFG_W    = 32;
    localparam int CIDX_W   = 1;

    // packed port widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_READ     = 2'd0,
        REQ_WRITE    = 2'd1,
        REQ_TOGGLE   = 2'd2,
        REQ_READ_ALL = 2'd3
    } req_t;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PIN    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_OUTPUT = 2'd2;

    // edge modes
    localparam logic [1:0] EDGE_NONE    = 2'd0;
    localparam logic [1:0] EDGE_RISING  = 2'd1;
    localparam logic [1:0] EDGE_FALLING = 2'd2;
    localparam logic [1:0] EDGE_BOTH    = 2'd3;

    // irq edge kinds
    localparam logic IRQ_RISE = 1'b0;
    localparam logic IRQ_FALL = 1'b1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_DIRECTION = 1'b0;
    localparam logic [CIDX_W-1:0] REG_EDGE      = 1'b1;

    // one result item
    typedef struct packed {
        logic [IRQPIN_W-1:0] irq_pin;
        logic                irq_edge;
        logic                irq_fire;
        logic [LEVELS_W-1:0] all_levels;
        logic                read_level;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

[design/gpio_pin_controller_edge_irq.sv]
// gpio_pin_controller_edge_irq: gpio pin controller with per-pin edge interrupts
// depends on gpioirq_pkg
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    tuser: req_type; tdata: pin_index, write_level
//  m_*       out  m_tvalid / m_tready    tdata: status .. irq_pin (one result per item)
//  cfg_*     in   cfg_we                 cfg_index, cfg_data (no read-back)
//
// each request is decoded against the level
// register in one combinational pass and lands in the result register,
// while the level register updates at the same edge
// an item is accepted each cycle while the result register is empty or being taken
// when m_tready is low with a result held, s_tready drops until it is taken
// rst_n clears pin levels, direction and edge modes and empties the result register
module gpio_pin_controller_edge_irq #(
    parameter int PIN_COUNT = gpioirq_pkg::PIN_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] req_type
    input  logic [gpioirq_pkg::REQ_W-1:0]       s_tuser,
    // [7:0] pin_index, [8] write_level, [15:9] zero
    input  logic [gpioirq_pkg::S_DATA_W-1:0]    s_tdata,
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [2] read_level, [18:3] all_levels, [19] irq_fire,
    // [20] irq_edge, [24:21] irq_pin, [31:25] zero
    output logic [gpioirq_pkg::M_DATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [gpioirq_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [gpioirq_pkg::CFG_W-1:0]       cfg_data
);
    import gpioirq_pkg::*;

    // pin select width, kept at least one bit for a single-pin build
    localparam int PIN_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

    // state
    logic [PIN_COUNT-1:0] levels_reg, levels_next;
    logic [CFG_PINS-1:0]  dir_reg;
    logic [CFG_W-1:0]     edge_reg;
    logic                 out_valid_reg;
    result_t              out_reg, out_next;

    // config extended to every pin: pins beyond the registers are inputs, mode none
    logic [PIN_COUNT-1:0] dir_ext;
    logic [1:0]           mode_ext [PIN_COUNT];
    logic [LEVELS_W-1:0]  levels16;

    genvar gi;
    generate
        for (gi = 0; gi < PIN_COUNT; gi++) begin : g_pin
            if (gi < CFG_PINS) begin : g_cfg
                assign dir_ext[gi]  = dir_reg[gi];
                assign mode_ext[gi] = edge_reg[2*gi+1 -: 2];
            end else begin : g_nocfg
                assign dir_ext[gi]  = 1'b0;
                assign mode_ext[gi] = EDGE_NONE;
            end
        end
        for (gi = 0; gi < LEVELS_W; gi++) begin : g_lev
            if (gi < PIN_COUNT) begin : g_have
                assign levels16[gi] = levels_reg[gi];
            end else begin : g_none
                assign levels16[gi] = 1'b0;
            end
        end
    endgenerate

    // request fields
    req_t              req;
    logic [PIDX_W-1:0] pin_index;
    logic              write_level;
    logic              accept;

    assign req         = req_t'(s_tuser);
    assign pin_index   = s_tdata[PIDX_W-1:0];
    assign write_level = s_tdata[PIDX_W];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // decode of the addressed pin
    logic             pin_ok;
    logic [PIN_W-1:0] sel;
    logic             cur_level;
    logic             is_out;
    logic [1:0]       mode;
    logic             new_level;

    assign pin_ok    = 32'(pin_index) < 32'(PIN_COUNT);
    assign sel       = pin_index[PIN_W-1:0];
    assign cur_level = pin_ok ? levels_reg[sel] : 1'b0;
    assign is_out    = pin_ok ? dir_ext[sel] : 1'b0;
    assign mode      = pin_ok ? mode_ext[sel] : EDGE_NONE;
    assign new_level = !cur_level;

    always_comb
    begin
        levels_next = levels_reg;
        out_next    = '0;
        case (req)
            REQ_READ_ALL:
            begin
                out_next.all_levels = levels16;
            end
            REQ_READ:
            begin
                if (!pin_ok)
                    out_next.status = ST_BAD_PIN;
                else
                    out_next.read_level = cur_level;
            end
            REQ_WRITE:
            begin
                if (!pin_ok)
                    out_next.status = ST_BAD_PIN;
                else if (!is_out)
                    out_next.status = ST_NOT_OUTPUT;
                else
                    levels_next[sel] = write_level;
            end
            REQ_TOGGLE:
            begin
                if (!pin_ok)
                    out_next.status = ST_BAD_PIN;
                else if (is_out)
                    // toggles on outputs are ignored, level reported
                    out_next.read_level = cur_level;
                else
                begin
                    levels_next[sel]    = new_level;
                    out_next.read_level = new_level;
                    if (mode == EDGE_BOTH || (mode == EDGE_RISING && new_level)
                        || (mode == EDGE_FALLING && !new_level))
                    begin
                        out_next.irq_fire = 1'b1;
                        out_next.irq_edge = new_level ? IRQ_RISE : IRQ_FALL;
                        out_next.irq_pin  = pin_index[IRQPIN_W-1:0];
                    end
                end
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg    <= '0;
            dir_reg       <= '0;
            edge_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIRECTION: dir_reg  <= cfg_data[CFG_PINS-1:0];
                    REG_EDGE:      edge_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if (accept)
            begin
                levels_reg    <= levels_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - $bits(result_t))'(0), out_reg};

endmodule

[design/gpioirq_checker.sv]
// gpioirq_checker: port-level checks for the gpio edge-interrupt block
// depends on gpioirq_pkg; bound to gpio_pin_controller_edge_irq below
module gpioirq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [gpioirq_pkg::M_DATA_W-1:0]    m_tdata
);
    import gpioirq_pkg::*;

    result_t res;
    assign res = m_tdata[$bits(result_t)-1:0];

    // a held result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // input side never blocks when no result is pending
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // an accepted item always yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

    // an interrupt only comes with status ok and no all-levels data
    a_irq_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.irq_fire |-> res.status == ST_OK && res.all_levels == '0)
        else $error("interrupt with bad status or levels");

    // no interrupt means the edge and pin fields stay clear
    a_irq_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.irq_fire |-> !res.irq_edge && res.irq_pin == '0)
        else $error("irq fields set without interrupt");

endmodule

bind gpio_pin_controller_edge_irq gpioirq_checker u_gpioirq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
